[hw/rtl/tnc_pkg.sv]
// types, codes and helpers shared by the trackball navigation click qualifier
// no dependencies; used by tnc_nav, tnc_click and trackball_nav_click_qualifier
`default_nettype none

package tnc_pkg;

	// key kinds on the result beat
	typedef enum logic [2:0] {
		KIND_NONE     = 3'd0,
		KIND_KEYBOARD = 3'd1,
		KIND_UP       = 3'd2,
		KIND_DOWN     = 3'd3,
		KIND_LEFT     = 3'd4,
		KIND_RIGHT    = 3'd5,
		KIND_ENTER    = 3'd6
	} tnc_kind_t;

	// configuration register indexes
	localparam logic [2:0] REG_NAV_RATE     = 3'd0;
	localparam logic [2:0] REG_NAV_THRESH   = 3'd1;
	localparam logic [2:0] REG_LONG_PRESS   = 3'd2;
	localparam logic [2:0] REG_DEBOUNCE     = 3'd3;
	localparam logic [2:0] REG_TOUCH_POLL   = 3'd4;
	localparam logic [2:0] REG_KB_ENABLE    = 3'd5;
	localparam logic [2:0] REG_TB_ENABLE    = 3'd6;
	localparam logic [2:0] REG_TOUCH_ENABLE = 3'd7;

	localparam int unsigned CFG_W = 16;

	// register reset values
	localparam logic [15:0] RST_NAV_RATE   = 16'd100;
	localparam logic [4:0]  RST_NAV_THRESH = 5'd3;
	localparam logic [15:0] RST_LONG_PRESS = 16'd800;
	localparam logic [15:0] RST_DEBOUNCE   = 16'd50;
	localparam logic [15:0] RST_TOUCH_POLL = 16'd20;

	typedef struct packed {
		logic [15:0] nav_rate_ms;
		logic [4:0]  nav_threshold;
		logic [15:0] hold_ms;
		logic [15:0] debounce_ms;
		logic [15:0] touch_gap_ms;
		logic        kb_enable;
		logic        tb_enable;
		logic        touch_enable;
	} tnc_cfg_t;

	typedef struct packed {
		logic [31:0]       now_ms;
		logic              kb_valid;
		logic [7:0]        kb_code;
		logic              tb_moved;
		logic signed [7:0] delta_x;
		logic signed [7:0] delta_y;
		logic              click_down;
		logic              touched;
	} tnc_in_t;

	typedef struct packed {
		logic [2:0] key_kind;
		logic [7:0] key_code;
		logic       long_press;
		logic       activity;
		logic       strong_activity;
	} tnc_out_t;

	// navigation unit status toward the top level and click unit
	typedef struct packed {
		logic      fire;
		tnc_kind_t kind;
	} tnc_nav_t;

	// click unit status
	typedef struct packed {
		logic press_start;
		logic long_press;
		logic enter;
	} tnc_click_t;

	// true once at least ms milliseconds passed since last, modulo 2^32
	function automatic logic interval_done(input logic [31:0] now, input logic [31:0] last,
			input logic [15:0] ms);
		logic [31:0] diff;
		diff = now - last;
		return diff >= {16'd0, ms};
	endfunction

endpackage

`default_nettype wire

[hw/rtl/tnc_nav.sv]
// trackball accumulators with saturation, dominant-axis pick and nav rate limit
// depends on tnc_pkg
`default_nettype none

module tnc_nav #(
	parameter int ACCUM_LIMIT = 20
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire logic              tb_en,
	input  wire logic              kb_hit,
	input  wire logic              enter,
	input  wire logic [31:0]       now_ms,
	input  wire logic signed [7:0] delta_x,
	input  wire logic signed [7:0] delta_y,
	input  wire logic [15:0]       nav_rate_ms,
	input  wire logic [4:0]        nav_threshold,
	output tnc_pkg::tnc_nav_t      nav
);

	localparam int ACC_W = $clog2(ACCUM_LIMIT + 1) + 1;
	localparam int SUM_W = ((ACC_W > 8) ? ACC_W : 8) + 1;
	localparam int CMP_W = (ACC_W > 5) ? ACC_W : 5;
	localparam logic signed [SUM_W-1:0] LIM_POS = SUM_W'(ACCUM_LIMIT);
	localparam logic signed [SUM_W-1:0] LIM_NEG = -LIM_POS;

	logic signed [ACC_W-1:0] accum_x_q, accum_y_q;
	logic [31:0]             last_nav_q;

	logic signed [SUM_W-1:0] sum_x, sum_y;
	logic signed [ACC_W-1:0] sat_x, sat_y;
	logic [ACC_W-1:0]        mag_x, mag_y;
	logic                    ydom, over_thr, rate_ok, fire;

	always_comb begin
		sum_x = SUM_W'(accum_x_q) + SUM_W'(delta_x);
		sum_y = SUM_W'(accum_y_q) + SUM_W'(delta_y);
		if (sum_x > LIM_POS) begin
			sat_x = ACC_W'(LIM_POS);
		end else if (sum_x < LIM_NEG) begin
			sat_x = ACC_W'(LIM_NEG);
		end else begin
			sat_x = ACC_W'(sum_x);
		end
		if (sum_y > LIM_POS) begin
			sat_y = ACC_W'(LIM_POS);
		end else if (sum_y < LIM_NEG) begin
			sat_y = ACC_W'(LIM_NEG);
		end else begin
			sat_y = ACC_W'(sum_y);
		end
		mag_x = sat_x[ACC_W-1] ? ACC_W'(-sat_x) : ACC_W'(sat_x);
		mag_y = sat_y[ACC_W-1] ? ACC_W'(-sat_y) : ACC_W'(sat_y);
		// y wins ties
		ydom     = mag_y >= mag_x;
		over_thr = ydom ? (CMP_W'(mag_y) >= CMP_W'(nav_threshold))
		                : (CMP_W'(mag_x) >= CMP_W'(nav_threshold));
		rate_ok  = tnc_pkg::interval_done(now_ms, last_nav_q, nav_rate_ms);
		fire     = tb_en && !kb_hit && rate_ok && over_thr;
	end

	always_comb begin
		nav.fire = fire;
		if (ydom) begin
			nav.kind = sat_y[ACC_W-1] ? tnc_pkg::KIND_UP : tnc_pkg::KIND_DOWN;
		end else begin
			nav.kind = sat_x[ACC_W-1] ? tnc_pkg::KIND_LEFT : tnc_pkg::KIND_RIGHT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_x_q  <= '0;
			accum_y_q  <= '0;
			last_nav_q <= '0;
		end else if (step && tb_en) begin
			if (enter || fire) begin
				accum_x_q <= '0;
				accum_y_q <= '0;
			end else if (!kb_hit) begin
				accum_x_q <= sat_x;
				accum_y_q <= sat_y;
			end
			if (enter || fire) begin
				last_nav_q <= now_ms;
			end
		end
	end

endmodule

`default_nettype wire

[hw/rtl/tnc_click.sv]
// click button qualifier: press tracking, long press and debounced release
// depends on tnc_pkg
`default_nettype none

module tnc_click (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        step,
	input  wire logic        tb_en,
	input  wire logic        click_down,
	input  wire logic        key_busy,
	input  wire logic [31:0] now_ms,
	input  wire logic [15:0] hold_ms,
	input  wire logic [15:0] debounce_ms,
	output tnc_pkg::tnc_click_t click
);

	logic        pending_q, long_fired_q;
	logic [31:0] start_q, last_down_q;
	logic        release_ok;

	always_comb begin
		release_ok = tb_en && !click_down && pending_q &&
		             tnc_pkg::interval_done(now_ms, last_down_q, debounce_ms);
		click.press_start = tb_en && click_down && !pending_q;
		click.long_press  = tb_en && click_down && pending_q && !long_fired_q &&
		                    tnc_pkg::interval_done(now_ms, start_q, hold_ms);
		click.enter       = release_ok && !long_fired_q && !key_busy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q    <= 1'b0;
			long_fired_q <= 1'b0;
			start_q      <= '0;
			last_down_q  <= '0;
		end else if (step && tb_en) begin
			if (click_down) begin
				last_down_q <= now_ms;
				if (!pending_q) begin
					pending_q    <= 1'b1;
					long_fired_q <= 1'b0;
					start_q      <= now_ms;
				end else if (click.long_press) begin
					long_fired_q <= 1'b1;
				end
			end else if (release_ok) begin
				pending_q    <= 1'b0;
				long_fired_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

[hw/rtl/trackball_nav_click_qualifier.sv]
// top level of the trackball navigation click qualifier
// depends on tnc_pkg, tnc_nav, tnc_click
//
//   channel | signals                         | beat moves when
//   --------+---------------------------------+---------------------------
//   in      | in_valid, in_stall, in_data     | in_valid && !in_stall
//   out     | out_valid, out_stall, out_data  | out_valid && !out_stall
//   cfg     | cfg_we, cfg_index, cfg_wdata    | cfg_we
//
// one poll beat per cycle sustained while out_stall is low; a beat passes from the
// input register into the result register, which drives out_data
// all state updates happen in the single cycle a beat moves from the input
// register into the result register, so the next poll sees them at once
// arst_n clears the registers to their defaults and the state to zero
// a stalled result holds the input register; in_stall rises only then
`default_nettype none

module trackball_nav_click_qualifier #(
	parameter int ACCUM_LIMIT = 20
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_stall,
	input  wire tnc_pkg::tnc_in_t        in_data,
	output logic                         out_valid,
	input  wire logic                    out_stall,
	output tnc_pkg::tnc_out_t            out_data,
	input  wire logic                    cfg_we,
	input  wire logic [2:0]              cfg_index,
	input  wire logic [tnc_pkg::CFG_W-1:0] cfg_wdata
);

	// configuration registers
	tnc_pkg::tnc_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.nav_rate_ms   <= tnc_pkg::RST_NAV_RATE;
			cfg_q.nav_threshold <= tnc_pkg::RST_NAV_THRESH;
			cfg_q.hold_ms       <= tnc_pkg::RST_LONG_PRESS;
			cfg_q.debounce_ms   <= tnc_pkg::RST_DEBOUNCE;
			cfg_q.touch_gap_ms  <= tnc_pkg::RST_TOUCH_POLL;
			cfg_q.kb_enable     <= 1'b1;
			cfg_q.tb_enable     <= 1'b1;
			cfg_q.touch_enable  <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				tnc_pkg::REG_NAV_RATE:     cfg_q.nav_rate_ms   <= cfg_wdata;
				tnc_pkg::REG_NAV_THRESH:   cfg_q.nav_threshold <= cfg_wdata[4:0];
				tnc_pkg::REG_LONG_PRESS:   cfg_q.hold_ms       <= cfg_wdata;
				tnc_pkg::REG_DEBOUNCE:     cfg_q.debounce_ms   <= cfg_wdata;
				tnc_pkg::REG_TOUCH_POLL:   cfg_q.touch_gap_ms  <= cfg_wdata;
				tnc_pkg::REG_KB_ENABLE:    cfg_q.kb_enable     <= cfg_wdata[0];
				tnc_pkg::REG_TB_ENABLE:    cfg_q.tb_enable     <= cfg_wdata[0];
				tnc_pkg::REG_TOUCH_ENABLE: cfg_q.touch_enable  <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	// pipeline control: input register s1, result register s2
	tnc_pkg::tnc_in_t  item_s1;
	logic              valid_s1;
	tnc_pkg::tnc_out_t result_s2;
	logic              valid_s2;
	logic              advance, step;

	assign advance  = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !advance;
	// a poll is processed and commits its state here
	assign step     = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1 <= in_data;
		end
	end

	// keyboard passes straight through
	logic kb_hit;
	assign kb_hit = cfg_q.kb_enable && item_s1.kb_valid;

	// trackball navigation
	tnc_pkg::tnc_nav_t   nav;
	tnc_pkg::tnc_click_t click;

	tnc_nav #(
		.ACCUM_LIMIT(ACCUM_LIMIT)
	) u_nav (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.tb_en        (cfg_q.tb_enable),
		.kb_hit       (kb_hit),
		.enter        (click.enter),
		.now_ms       (item_s1.now_ms),
		.delta_x      (item_s1.delta_x),
		.delta_y      (item_s1.delta_y),
		.nav_rate_ms  (cfg_q.nav_rate_ms),
		.nav_threshold(cfg_q.nav_threshold),
		.nav          (nav)
	);

	// click qualification; enter is blocked when the same poll sends another key
	tnc_click u_click (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.tb_en        (cfg_q.tb_enable),
		.click_down   (item_s1.click_down),
		.key_busy     (kb_hit || nav.fire),
		.now_ms       (item_s1.now_ms),
		.hold_ms      (cfg_q.hold_ms),
		.debounce_ms  (cfg_q.debounce_ms),
		.click        (click)
	);

	// touch sampling at a throttled rate
	logic [31:0] last_touch_q;
	logic        touch_sample, touch_hit;

	assign touch_sample = cfg_q.touch_enable &&
	                      tnc_pkg::interval_done(item_s1.now_ms, last_touch_q,
	                                             cfg_q.touch_gap_ms);
	assign touch_hit    = touch_sample && item_s1.touched;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_touch_q <= '0;
		end else if (step && touch_sample) begin
			last_touch_q <= item_s1.now_ms;
		end
	end

	// result assembly
	tnc_pkg::tnc_out_t result;
	logic              key_out, wake;

	always_comb begin
		// a long press swallows any key of the same poll
		key_out = ((kb_hit || nav.fire) && !click.long_press) || click.enter;
		wake    = kb_hit || nav.fire || click.press_start || click.long_press ||
		          click.enter || touch_hit;
		result.key_code = '0;
		if (!key_out) begin
			result.key_kind = tnc_pkg::KIND_NONE;
		end else if (click.enter) begin
			result.key_kind = tnc_pkg::KIND_ENTER;
		end else if (nav.fire) begin
			result.key_kind = nav.kind;
		end else begin
			result.key_kind = tnc_pkg::KIND_KEYBOARD;
			result.key_code = item_s1.kb_code;
		end
		result.long_press      = click.long_press;
		result.strong_activity = wake;
		// weak trackball motion counts as activity but not as wake
		result.activity        = wake || (cfg_q.tb_enable && item_s1.tb_moved);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			result_s2 <= result;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = result_s2;

	// checks
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with empty input register");

	a_step_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> valid_s2)
		else $error("processed poll produced no result beat");

	a_long_press_no_key: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && result_s2.long_press) |-> (result_s2.key_kind == tnc_pkg::KIND_NONE))
		else $error("key reported together with long press");

	a_strong_is_active: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && result_s2.strong_activity) |-> result_s2.activity)
		else $error("strong activity without activity");

	a_code_only_keyboard: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && (result_s2.key_kind != tnc_pkg::KIND_KEYBOARD)) |->
		(result_s2.key_code == '0))
		else $error("key code set on a non-keyboard beat");

endmodule

`default_nettype wire
